// ----- hdl/sha_pkg.sv -----
// shared types, constants and tables of the sha-256 byte stream hasher
`timescale 1ns / 1ps
package sha_pkg;

  localparam logic KindByte   = 1'b0;
  localparam logic KindFinish = 1'b1;

  localparam logic [7:0]  PadMark   = 8'h80;
  localparam logic [5:0]  LenOffset = 6'd56;
  localparam logic [5:0]  LastByte  = 6'd63;
  localparam logic [5:0]  LastRound = 6'd63;
  localparam logic [31:0] CountMax  = 32'hFFFF_FFFF;

  typedef logic [7:0][31:0] sha_words_t;

  typedef struct packed {
    logic       push;
    logic [7:0] data;
    logic       start;
    logic       step;
  } sha_ctl_t;

  function automatic logic [31:0] sha_iv(input logic [2:0] idx);
    logic [31:0] v;
    case (idx)
      3'd0:    v = 32'h6a09e667;
      3'd1:    v = 32'hbb67ae85;
      3'd2:    v = 32'h3c6ef372;
      3'd3:    v = 32'ha54ff53a;
      3'd4:    v = 32'h510e527f;
      3'd5:    v = 32'h9b05688c;
      3'd6:    v = 32'h1f83d9ab;
      default: v = 32'h5be0cd19;
    endcase
    return v;
  endfunction

  function automatic logic [31:0] sha_k(input logic [5:0] idx);
    logic [31:0] v;
    case (idx)
      6'd0:  v = 32'h428a2f98;  6'd1:  v = 32'h71374491;
      6'd2:  v = 32'hb5c0fbcf;  6'd3:  v = 32'he9b5dba5;
      6'd4:  v = 32'h3956c25b;  6'd5:  v = 32'h59f111f1;
      6'd6:  v = 32'h923f82a4;  6'd7:  v = 32'hab1c5ed5;
      6'd8:  v = 32'hd807aa98;  6'd9:  v = 32'h12835b01;
      6'd10: v = 32'h243185be;  6'd11: v = 32'h550c7dc3;
      6'd12: v = 32'h72be5d74;  6'd13: v = 32'h80deb1fe;
      6'd14: v = 32'h9bdc06a7;  6'd15: v = 32'hc19bf174;
      6'd16: v = 32'he49b69c1;  6'd17: v = 32'hefbe4786;
      6'd18: v = 32'h0fc19dc6;  6'd19: v = 32'h240ca1cc;
      6'd20: v = 32'h2de92c6f;  6'd21: v = 32'h4a7484aa;
      6'd22: v = 32'h5cb0a9dc;  6'd23: v = 32'h76f988da;
      6'd24: v = 32'h983e5152;  6'd25: v = 32'ha831c66d;
      6'd26: v = 32'hb00327c8;  6'd27: v = 32'hbf597fc7;
      6'd28: v = 32'hc6e00bf3;  6'd29: v = 32'hd5a79147;
      6'd30: v = 32'h06ca6351;  6'd31: v = 32'h14292967;
      6'd32: v = 32'h27b70a85;  6'd33: v = 32'h2e1b2138;
      6'd34: v = 32'h4d2c6dfc;  6'd35: v = 32'h53380d13;
      6'd36: v = 32'h650a7354;  6'd37: v = 32'h766a0abb;
      6'd38: v = 32'h81c2c92e;  6'd39: v = 32'h92722c85;
      6'd40: v = 32'ha2bfe8a1;  6'd41: v = 32'ha81a664b;
      6'd42: v = 32'hc24b8b70;  6'd43: v = 32'hc76c51a3;
      6'd44: v = 32'hd192e819;  6'd45: v = 32'hd6990624;
      6'd46: v = 32'hf40e3585;  6'd47: v = 32'h106aa070;
      6'd48: v = 32'h19a4c116;  6'd49: v = 32'h1e376c08;
      6'd50: v = 32'h2748774c;  6'd51: v = 32'h34b0bcb5;
      6'd52: v = 32'h391c0cb3;  6'd53: v = 32'h4ed8aa4a;
      6'd54: v = 32'h5b9cca4f;  6'd55: v = 32'h682e6ff3;
      6'd56: v = 32'h748f82ee;  6'd57: v = 32'h78a5636f;
      6'd58: v = 32'h84c87814;  6'd59: v = 32'h8cc70208;
      6'd60: v = 32'h90befffa;  6'd61: v = 32'ha4506ceb;
      6'd62: v = 32'hbef9a3f7;
      default: v = 32'hc67178f2;
    endcase
    return v;
  endfunction

endpackage

// ----- hdl/sha_if.sv -----
// valid/ready channel interfaces for message bytes and digest words
`timescale 1ns / 1ps
interface sha_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] data_byte;

  modport source (output valid, output kind, output data_byte, input ready);
  modport sink (input valid, input kind, input data_byte, output ready);
endinterface

interface sha_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;
  logic        length_overflow;

  modport source (output valid, output digest_word, output word_index, output last_word,
                  output length_overflow, input ready);
  modport sink (input valid, input digest_word, input word_index, input last_word,
                input length_overflow, output ready);
endinterface

// ----- hdl/sha_core.sv -----
// sha-256 round unit: byte-loaded schedule window, working variables, round counter
`timescale 1ns / 1ps
module sha_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  sha_pkg::sha_ctl_t  ctl_i,
  input  sha_pkg::sha_words_t chain_i,
  output sha_pkg::sha_words_t work_o,
  output logic               last_round_o
);

  logic [5:0]          rnd_q;
  sha_pkg::sha_words_t work_q;
  logic [15:0][31:0]   win_q;

  logic [31:0] w_sched;
  logic [31:0] w_cur;
  logic [31:0] t1;
  logic [31:0] t2;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

  always_comb begin
    w_sched = (rotr(win_q[14], 17) ^ rotr(win_q[14], 19) ^ (win_q[14] >> 10)) + win_q[9]
            + (rotr(win_q[1], 7) ^ rotr(win_q[1], 18) ^ (win_q[1] >> 3)) + win_q[0];
    w_cur   = (rnd_q[5:4] == 2'b00) ? win_q[0] : w_sched;
    t1 = work_q[7] + (rotr(work_q[4], 6) ^ rotr(work_q[4], 11) ^ rotr(work_q[4], 25))
       + ((work_q[4] & work_q[5]) ^ (~work_q[4] & work_q[6]))
       + sha_pkg::sha_k(rnd_q) + w_cur;
    t2 = (rotr(work_q[0], 2) ^ rotr(work_q[0], 13) ^ rotr(work_q[0], 22))
       + ((work_q[0] & work_q[1]) ^ (work_q[0] & work_q[2]) ^ (work_q[1] & work_q[2]));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rnd_q <= '0;
    end else if (ctl_i.start) begin
      rnd_q <= '0;
    end else if (ctl_i.step) begin
      rnd_q <= rnd_q + 6'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.start) begin
      work_q <= chain_i;
    end else if (ctl_i.step) begin
      work_q[7] <= work_q[6];
      work_q[6] <= work_q[5];
      work_q[5] <= work_q[4];
      work_q[4] <= work_q[3] + t1;
      work_q[3] <= work_q[2];
      work_q[2] <= work_q[1];
      work_q[1] <= work_q[0];
      work_q[0] <= t1 + t2;
    end
  end

  // bytes enter big-endian at the tail; rounds shift whole words
  always_ff @(posedge clk_i) begin
    if (ctl_i.push) begin
      for (int i = 0; i < 15; i++) begin
        win_q[i] <= {win_q[i][23:0], win_q[i+1][31:24]};
      end
      win_q[15] <= {win_q[15][23:0], ctl_i.data};
    end else if (ctl_i.step) begin
      for (int i = 0; i < 15; i++) begin
        win_q[i] <= win_q[i+1];
      end
      win_q[15] <= w_cur;
    end
  end

  assign work_o       = work_q;
  assign last_round_o = (rnd_q == sha_pkg::LastRound);

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.start |=> rnd_q == 6'd0)
    else $error("round counter not cleared at block start");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.step && !ctl_i.start |=> rnd_q == $past(rnd_q) + 6'd1)
    else $error("round counter did not advance");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ctl_i.push && ctl_i.step))
    else $error("byte load during a round");

endmodule

// ----- hdl/sha256_byte_stream_hasher.sv -----
// top level: byte intake, padding sequencer, chaining value and digest output
//
// One message byte is taken per cycle while idle. The byte that completes a
// 64-byte block starts a compression (64 rounds, one per cycle in a single
// round unit, then a fold step that adds into the chaining value) during
// which no input is taken. A finish item feeds the padding bytes one per
// cycle up to the end of the block (one or two blocks, up to 72 bytes of
// padding), runs the compression for each, and then presents the eight
// digest words one per cycle as the sink takes them, word 0 first. The next
// message is accepted after the eighth word transfer.
`timescale 1ns / 1ps
module sha256_byte_stream_hasher (
  input  logic       clk_i,
  input  logic       rst_ni,
  sha_in_if.sink     in_i,
  sha_out_if.source  out_o
);

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StPad   = 3'd1;
  localparam logic [2:0] StRound = 3'd2;
  localparam logic [2:0] StFold  = 3'd3;
  localparam logic [2:0] StOut   = 3'd4;

  logic [2:0]          state_q, state_d;
  logic [5:0]          fill_q, fill_d;
  logic [31:0]         count_q, count_d;
  logic                ovf_q, ovf_d;
  logic                fin_q, fin_d;
  logic                mark_q, mark_d;
  logic                xtra_q, xtra_d;
  logic                last_q, last_d;
  logic [2:0]          widx_q, widx_d;
  sha_pkg::sha_words_t chain_q, chain_d;

  sha_pkg::sha_ctl_t   ctl;
  sha_pkg::sha_words_t work;
  logic                last_round;

  logic        in_xfer;
  logic        out_xfer;
  logic [63:0] len_bits;
  logic        len_phase;
  logic [7:0]  pad_val;
  logic        take_byte;
  logic        wrap;

  assign in_i.ready = (state_q == StIdle);
  assign in_xfer    = in_i.valid && in_i.ready;
  assign out_xfer   = out_o.valid && out_o.ready;

  assign len_bits  = {29'd0, count_q, 3'd0};
  assign len_phase = !mark_q && !xtra_q && (fill_q >= sha_pkg::LenOffset);

  always_comb begin
    if (mark_q) begin
      pad_val = sha_pkg::PadMark;
    end else if (len_phase) begin
      pad_val = len_bits[{~fill_q[2:0], 3'b000} +: 8];
    end else begin
      pad_val = 8'h00;
    end
  end

  assign take_byte = in_xfer && (in_i.kind == sha_pkg::KindByte)
                     && (count_q != sha_pkg::CountMax);

  always_comb begin
    ctl.push  = take_byte || (state_q == StPad);
    ctl.data  = (state_q == StPad) ? pad_val : in_i.data_byte;
    wrap      = ctl.push && (fill_q == sha_pkg::LastByte);
    ctl.start = wrap;
    ctl.step  = (state_q == StRound);
  end

  sha_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctl_i        (ctl),
    .chain_i      (chain_q),
    .work_o       (work),
    .last_round_o (last_round)
  );

  always_comb begin
    state_d = state_q;
    fill_d  = ctl.push ? fill_q + 6'd1 : fill_q;
    count_d = count_q;
    ovf_d   = ovf_q;
    fin_d   = fin_q;
    mark_d  = mark_q;
    xtra_d  = xtra_q;
    last_d  = last_q;
    widx_d  = widx_q;
    chain_d = chain_q;
    case (state_q)
      StIdle: begin
        if (in_xfer) begin
          if (in_i.kind == sha_pkg::KindFinish) begin
            state_d = StPad;
            fin_d   = 1'b1;
            mark_d  = 1'b1;
          end else if (count_q == sha_pkg::CountMax) begin
            ovf_d = 1'b1;
          end else begin
            count_d = count_q + 32'd1;
            if (wrap) begin
              state_d = StRound;
            end
          end
        end
      end
      StPad: begin
        mark_d = 1'b0;
        // marker too late for the length field: pad out an extra block
        if (mark_q && (fill_q >= sha_pkg::LenOffset)) begin
          xtra_d = 1'b1;
        end
        if (wrap) begin
          xtra_d  = 1'b0;
          last_d  = len_phase;
          state_d = StRound;
        end
      end
      StRound: begin
        if (last_round) begin
          state_d = StFold;
        end
      end
      StFold: begin
        for (int i = 0; i < 8; i++) begin
          chain_d[i] = chain_q[i] + work[i];
        end
        if (last_q) begin
          state_d = StOut;
          widx_d  = 3'd0;
        end else if (fin_q) begin
          state_d = StPad;
        end else begin
          state_d = StIdle;
        end
      end
      StOut: begin
        if (out_xfer) begin
          widx_d = widx_q + 3'd1;
          if (widx_q == 3'd7) begin
            state_d = StIdle;
            count_d = '0;
            ovf_d   = 1'b0;
            fin_d   = 1'b0;
            last_d  = 1'b0;
            for (int i = 0; i < 8; i++) begin
              chain_d[i] = sha_pkg::sha_iv(3'(i));
            end
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      fill_q  <= '0;
      count_q <= '0;
      ovf_q   <= 1'b0;
      fin_q   <= 1'b0;
      mark_q  <= 1'b0;
      xtra_q  <= 1'b0;
      last_q  <= 1'b0;
      widx_q  <= '0;
      for (int i = 0; i < 8; i++) begin
        chain_q[i] <= sha_pkg::sha_iv(3'(i));
      end
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
      count_q <= count_d;
      ovf_q   <= ovf_d;
      fin_q   <= fin_d;
      mark_q  <= mark_d;
      xtra_q  <= xtra_d;
      last_q  <= last_d;
      widx_q  <= widx_d;
      chain_q <= chain_d;
    end
  end

  assign out_o.valid           = (state_q == StOut);
  assign out_o.digest_word     = chain_q[widx_q];
  assign out_o.word_index      = widx_q;
  assign out_o.last_word       = (widx_q == 3'd7);
  assign out_o.length_overflow = ovf_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_i.ready && out_o.valid))
    else $error("input taken while digest pending");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StOut |-> fill_q == 6'd0 && fin_q && !mark_q && !xtra_q)
    else $error("padding state left over at digest output");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StFold |-> $past(state_q) == StRound)
    else $error("chain update without a finished compression");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_xfer && out_o.last_word |=> chain_q[0] == sha_pkg::sha_iv(3'd0) && count_q == 32'd0)
    else $error("hash state not restarted after digest");

endmodule

// ----- test/testbench.sv -----
// self-checking testbench for the sha-256 byte stream hasher
`timescale 1ns / 1ps
module testbench;

  typedef struct packed {
    logic       kind;
    logic [7:0] data;
  } msg_item_t;

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  idx;
    logic        last;
    logic        ovf;
  } digest_entry_t;

  localparam logic [0:63][31:0] RoundK = {
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [0:7][31:0] InitHash = {
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  logic clk_i;
  logic rst_ni;

  sha_in_if  in_if ();
  sha_out_if out_if ();

  sha256_byte_stream_hasher dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  msg_item_t     byte_stream_q[$];
  digest_entry_t digest_q[$];

  logic [31:0] chain_h [8];
  logic [7:0]  block_bytes [64];
  int          fill_pos;
  logic [31:0] msg_len;
  logic        len_wrapped;

  int in_idle_pct;
  int out_stall_pct;
  int errors;
  int bytes_taken;
  int digests_taken;
  int words_checked;

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  function automatic logic [31:0] ror32(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic void compress_block();
    logic [31:0] w [16];
    logic [31:0] v [8];
    logic [31:0] nw;
    logic [31:0] t1;
    logic [31:0] t2;
    for (int t = 0; t < 16; t++) begin
      w[t] = {block_bytes[4*t], block_bytes[4*t+1], block_bytes[4*t+2], block_bytes[4*t+3]};
    end
    for (int t = 0; t < 8; t++) v[t] = chain_h[t];
    for (int r = 0; r < 64; r++) begin
      if (r < 16) begin
        nw = w[r];
      end else begin
        nw = (ror32(w[(r-2)&15], 17) ^ ror32(w[(r-2)&15], 19) ^ (w[(r-2)&15] >> 10))
           + w[(r-7)&15]
           + (ror32(w[(r-15)&15], 7) ^ ror32(w[(r-15)&15], 18) ^ (w[(r-15)&15] >> 3))
           + w[r&15];
        w[r&15] = nw;
      end
      t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + RoundK[r] + nw;
      t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6];
      v[6] = v[5];
      v[5] = v[4];
      v[4] = v[3] + t1;
      v[3] = v[2];
      v[2] = v[1];
      v[1] = v[0];
      v[0] = t1 + t2;
    end
    for (int t = 0; t < 8; t++) chain_h[t] = chain_h[t] + v[t];
  endfunction

  function automatic void restart_hash();
    for (int t = 0; t < 8; t++) chain_h[t] = InitHash[t];
    fill_pos    = 0;
    msg_len     = '0;
    len_wrapped = 1'b0;
  endfunction

  function automatic void absorb_item(input logic kind, input logic [7:0] data);
    logic [63:0]   bit_len;
    digest_entry_t e;
    if (kind == sha_pkg::KindByte) begin
      if (msg_len == sha_pkg::CountMax) begin
        len_wrapped = 1'b1;
      end else begin
        msg_len = msg_len + 32'd1;
        block_bytes[fill_pos] = data;
        fill_pos++;
        if (fill_pos == 64) begin
          compress_block();
          fill_pos = 0;
        end
      end
    end else begin
      bit_len = {29'b0, msg_len, 3'b0};
      block_bytes[fill_pos] = sha_pkg::PadMark;
      for (int i = fill_pos + 1; i < 64; i++) block_bytes[i] = 8'h00;
      if (fill_pos >= 56) begin
        compress_block();
        for (int i = 0; i < 64; i++) block_bytes[i] = 8'h00;
      end
      for (int i = 0; i < 8; i++) block_bytes[56+i] = bit_len[63-8*i -: 8];
      compress_block();
      for (int i = 0; i < 8; i++) begin
        e.word = chain_h[i];
        e.idx  = 3'(i);
        e.last = (i == 7);
        e.ovf  = len_wrapped;
        digest_q.push_back(e);
      end
      restart_hash();
    end
  endfunction

  task automatic report_mismatch(input string what);
    $display("ERROR at %0t: %s", $time, what);
    errors++;
  endtask

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_if.valid     <= 1'b0;
      in_if.kind      <= sha_pkg::KindByte;
      in_if.data_byte <= 8'h00;
    end else begin
      if (in_if.valid && in_if.ready) begin
        absorb_item(in_if.kind, in_if.data_byte);
        if (in_if.kind == sha_pkg::KindByte) bytes_taken++;
        else digests_taken++;
      end
      if (!in_if.valid || in_if.ready) begin
        if (byte_stream_q.size() != 0 && $urandom_range(99) >= in_idle_pct) begin
          in_if.valid     <= 1'b1;
          in_if.kind      <= byte_stream_q[0].kind;
          in_if.data_byte <= byte_stream_q[0].data;
          void'(byte_stream_q.pop_front());
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i or negedge rst_ni) begin
    digest_entry_t e;
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (digest_q.size() == 0) begin
          report_mismatch($sformatf("unexpected digest word %h", out_if.digest_word));
        end else begin
          e = digest_q.pop_front();
          words_checked++;
          if (out_if.digest_word !== e.word)
            report_mismatch($sformatf("word %0d: digest_word %h, want %h",
                                      e.idx, out_if.digest_word, e.word));
          if (out_if.word_index !== e.idx)
            report_mismatch($sformatf("word_index %0d, want %0d", out_if.word_index, e.idx));
          if (out_if.last_word !== e.last)
            report_mismatch($sformatf("word %0d: last_word %b, want %b",
                                      e.idx, out_if.last_word, e.last));
          if (out_if.length_overflow !== e.ovf)
            report_mismatch($sformatf("word %0d: length_overflow %b, want %b",
                                      e.idx, out_if.length_overflow, e.ovf));
        end
      end
      out_if.ready <= ($urandom_range(99) >= out_stall_pct);
    end
  end

  function automatic void push_item(input logic kind, input logic [7:0] data);
    msg_item_t it;
    it.kind = kind;
    it.data = data;
    byte_stream_q.push_back(it);
  endfunction

  function automatic void queue_message(input int len);
    for (int i = 0; i < len; i++) push_item(sha_pkg::KindByte, 8'($urandom));
    push_item(sha_pkg::KindFinish, 8'($urandom));
  endfunction

  // lengths around the padding and block boundaries, plus short and arbitrary ones
  function automatic int pick_length();
    int len;
    case ($urandom_range(3))
      0: len = $urandom_range(8);
      1: begin
        case ($urandom_range(7))
          0: len = 55;
          1: len = 56;
          2: len = 57;
          3: len = 63;
          4: len = 64;
          5: len = 65;
          6: len = 119;
          default: len = 120;
        endcase
      end
      2: len = $urandom_range(130);
      default: len = $urandom_range(20);
    endcase
    return len;
  endfunction

  initial begin
    int phase_items;
    rst_ni          = 1'b0;
    in_if.valid     = 1'b0;
    in_if.kind      = sha_pkg::KindByte;
    in_if.data_byte = 8'h00;
    out_if.ready    = 1'b0;
    in_idle_pct     = 0;
    out_stall_pct   = 0;
    errors          = 0;
    bytes_taken     = 0;
    digests_taken   = 0;
    words_checked   = 0;
    for (int i = 0; i < 64; i++) block_bytes[i] = 8'h00;
    restart_hash();
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // empty message with junk on the ignored byte, byte extremes, back-to-back finishes
    push_item(sha_pkg::KindFinish, 8'hFF);
    push_item(sha_pkg::KindByte, 8'h00);
    push_item(sha_pkg::KindByte, 8'hFF);
    push_item(sha_pkg::KindByte, 8'h55);
    push_item(sha_pkg::KindByte, 8'hAA);
    push_item(sha_pkg::KindByte, 8'h80);
    push_item(sha_pkg::KindByte, 8'h01);
    push_item(sha_pkg::KindFinish, 8'h00);
    push_item(sha_pkg::KindFinish, 8'h5A);
    push_item(sha_pkg::KindFinish, 8'hA5);

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin in_idle_pct = 0;  out_stall_pct = 0;  end
        1: begin in_idle_pct = 61; out_stall_pct = 0;  end
        2: begin in_idle_pct = 0;  out_stall_pct = 61; end
        default: begin in_idle_pct = 15; out_stall_pct = 15; end
      endcase
      phase_items = 0;
      while (phase_items < 50) begin
        int len;
        len = pick_length();
        queue_message(len);
        phase_items += len + 1;
      end
      // sender holds off until every digest word of the phase is out
      while (byte_stream_q.size() != 0 || in_if.valid || digest_q.size() != 0)
        @(posedge clk_i);
    end

    out_stall_pct = 0;
    repeat (200) @(posedge clk_i);

    $display("run covered %0d byte transfers and %0d digests (%0d words checked)",
             bytes_taken, digests_taken, words_checked);
    $display("idle and stall mixes on both channels, padding with one and two blocks");
    if (errors == 0 && digest_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      if (digest_q.size() != 0) $display("%0d digest words never arrived", digest_q.size());
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("timeout with %0d digest words outstanding", digest_q.size());
    $display("Simulation FAILED");
    $finish;
  end

endmodule
